/* rtl/core/config_script_tokenizer_top_assert.svh */
// Assertion macros used by the tokenizer queue.
// Each use expects aclk and aresetn in scope.
`ifndef CONFIG_SCRIPT_TOKENIZER_TOP_ASSERT_SVH
`define CONFIG_SCRIPT_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication
`define CST_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
    else $error("cst: assertion failed");

// next-cycle implication
`define CST_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
    else $error("cst: assertion failed");

`endif

/* rtl/core/cst_pkg.sv */
package cst_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int REC_MAX         = 6;
    localparam int REC_CNT_W       = $clog2(REC_MAX + 1);
    localparam int QDEPTH          = 2;

    // record types
    localparam logic [1:0] RT_TOKEN   = 2'd0;
    localparam logic [1:0] RT_PAYLOAD = 2'd1;
    localparam logic [1:0] RT_ERROR   = 2'd2;

    // token kinds
    localparam logic [5:0] K_END     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_TRUE    = 6'd2;
    localparam logic [5:0] K_FALSE   = 6'd3;
    localparam logic [5:0] K_NULL    = 6'd4;
    localparam logic [5:0] K_INCLUDE = 6'd5;
    localparam logic [5:0] K_INT     = 6'd6;
    localparam logic [5:0] K_FLOAT   = 6'd7;
    localparam logic [5:0] K_STRING  = 6'd8;
    localparam logic [5:0] K_LBRACE  = 6'd9;
    localparam logic [5:0] K_RBRACE  = 6'd10;
    localparam logic [5:0] K_LBRACK  = 6'd11;
    localparam logic [5:0] K_RBRACK  = 6'd12;
    localparam logic [5:0] K_LPAREN  = 6'd13;
    localparam logic [5:0] K_RPAREN  = 6'd14;
    localparam logic [5:0] K_SEMI    = 6'd15;
    localparam logic [5:0] K_COMMA   = 6'd16;
    localparam logic [5:0] K_DOT     = 6'd17;
    localparam logic [5:0] K_QUEST   = 6'd18;
    localparam logic [5:0] K_COLON   = 6'd19;
    localparam logic [5:0] K_PLUS    = 6'd20;
    localparam logic [5:0] K_MINUS   = 6'd21;
    localparam logic [5:0] K_STAR    = 6'd22;
    localparam logic [5:0] K_SLASH   = 6'd23;
    localparam logic [5:0] K_PERCENT = 6'd24;
    localparam logic [5:0] K_CARET   = 6'd25;
    localparam logic [5:0] K_TILDE   = 6'd26;
    localparam logic [5:0] K_ASSIGN  = 6'd27;
    localparam logic [5:0] K_EQ      = 6'd28;
    localparam logic [5:0] K_BANG    = 6'd29;
    localparam logic [5:0] K_NE      = 6'd30;
    localparam logic [5:0] K_LT      = 6'd31;
    localparam logic [5:0] K_LE      = 6'd32;
    localparam logic [5:0] K_SHL     = 6'd33;
    localparam logic [5:0] K_GT      = 6'd34;
    localparam logic [5:0] K_GE      = 6'd35;
    localparam logic [5:0] K_SHR     = 6'd36;
    localparam logic [5:0] K_AMP     = 6'd37;
    localparam logic [5:0] K_ANDAND  = 6'd38;
    localparam logic [5:0] K_PIPE    = 6'd39;
    localparam logic [5:0] K_OROR    = 6'd40;

    // error codes
    localparam logic [3:0] E_BLOCK_OPEN  = 4'd0;
    localparam logic [3:0] E_BAD_CHAR    = 4'd1;
    localparam logic [3:0] E_HEX_EMPTY   = 4'd2;
    localparam logic [3:0] E_DEC_RANGE   = 4'd3;
    localparam logic [3:0] E_STR_OPEN    = 4'd4;
    localparam logic [3:0] E_STR_NL      = 4'd5;
    localparam logic [3:0] E_ESC_EOF     = 4'd6;
    localparam logic [3:0] E_BAD_X       = 4'd7;
    localparam logic [3:0] E_U_NO_BRACE  = 4'd8;
    localparam logic [3:0] E_U_LONG      = 4'd9;
    localparam logic [3:0] E_U_EMPTY     = 4'd10;
    localparam logic [3:0] E_U_OPEN      = 4'd11;
    localparam logic [3:0] E_BAD_CP      = 4'd12;
    localparam logic [3:0] E_BAD_ESC     = 4'd13;

    typedef struct packed {
        logic [1:0]  rtype;
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] span;
        logic [7:0]  pbyte;
        logic [3:0]  ecode;
    } rec_t;

    // all records caused by one input beat; ival belongs to the int token
    typedef struct packed {
        logic [REC_CNT_W-1:0]   cnt;
        logic [63:0]            ival;
        rec_t [REC_MAX-1:0]     recs;
    } bundle_t;

endpackage

/* rtl/core/config_script_tokenizer_top.sv */
// A record reaches m_* through the bundle queue and then the output register.
// Throughput: one source byte per cycle while the queue is not full; one result record
// per cycle on m_* while m_tready is high. A byte's k records leave one by one; a two-entry
// bundle queue lets the lexer keep taking bytes while the output side drains.
// Reset: aresetn synchronous, active low; lexer idle at offset 0, queue empty.
module config_script_tokenizer_top import cst_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // source byte stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] src_byte
    input  logic         s_tlast,   // end_of_input
    // result record stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [5:0] token_kind, [37:6] start_offset, [69:38] span_length,
    // [133:70] integer_value, [141:134] payload_byte, [145:142] error_code, rest 0
    output logic [151:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] record_type
    output logic         m_tlast    // run_last
);

    // front -> queue
    logic    f_push;
    bundle_t f_bundle;
    // queue -> back
    bundle_t q_head;
    logic    q_full, q_empty, q_pop;
    // back -> ports
    rec_t        b_rec;
    logic [63:0] b_ival;

    // Front: one lexer state update per source beat. It gathers every record the
    // beat causes (reprocessed lookahead bytes, UTF-8 bytes, end token) into one
    // bundle and stalls only when the queue is full.
    cst_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .q_full   (q_full),
        .push     (f_push),
        .bundle   (f_bundle)
    );

    // Queue: decouples the byte rate from the record rate.
    cst_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_push),
        .wdata   (f_bundle),
        .pop     (q_pop),
        .rdata   (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: walks the head bundle one record per beat into the output register,
    // flagging the final record of the bundle as run_last.
    cst_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .head_valid (!q_empty),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rec    (b_rec),
        .out_ival   (b_ival),
        .out_last   (m_tlast)
    );

    assign m_tuser = b_rec.rtype;
    assign m_tdata = {6'd0, b_rec.ecode, b_rec.pbyte, b_ival, b_rec.span, b_rec.start,
                      b_rec.kind};

endmodule

/* rtl/core/cst_front.sv */
module cst_front import cst_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    input  logic       q_full,
    output logic       push,
    output bundle_t    bundle
);

    localparam int OW = OFFSET_BITS;
    typedef logic [OW-1:0] off_t;

    localparam logic [4:0] M_IDLE = 5'd0, M_LINE = 5'd1, M_BLOCK = 5'd2, M_BSTAR = 5'd3,
        M_SLASH = 5'd4, M_OP = 5'd5, M_IDENT = 5'd6, M_ZERO = 5'd7, M_INT = 5'd8,
        M_HEX0 = 5'd9, M_HEX = 5'd10, M_IDOT = 5'd11, M_FRAC = 5'd12, M_EXPE_I = 5'd13,
        M_EXPE_F = 5'd14, M_SGN_I = 5'd15, M_SGN_F = 5'd16, M_EXPD = 5'd17, M_STR = 5'd18,
        M_ESC = 5'd19, M_X1 = 5'd20, M_X2 = 5'd21, M_UBR = 5'd22, M_UDIG = 5'd23;

    localparam logic [67:0] INT_MAX68 = 68'h7FFF_FFFF_FFFF_FFFF;

    function automatic logic [31:0] to32(input off_t x);
        logic [63:0] w;
        w = 64'(x);
        return w[31:0];
    endfunction

    function automatic rec_t mk_rec(input logic [1:0] rt, input logic [5:0] kd,
                                    input logic [31:0] st, input logic [31:0] sp,
                                    input logic [7:0] pb, input logic [3:0] ec);
        rec_t r;
        r.rtype = rt; r.kind = kd; r.start = st; r.span = sp; r.pbyte = pb; r.ecode = ec;
        return r;
    endfunction

    function automatic rec_t mk_tok(input logic [5:0] kd, input off_t st, input off_t sp);
        return mk_rec(RT_TOKEN, kd, to32(st), to32(sp), 8'd0, 4'd0);
    endfunction

    function automatic rec_t mk_err(input logic [3:0] ec, input off_t at);
        return mk_rec(RT_ERROR, K_END, to32(at), 32'd0, 8'd0, ec);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") || ch == "_";
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return ch == " " || ch == 8'h09 || ch == 8'h0A || ch == 8'h0B || ch == 8'h0C ||
               ch == 8'h0D;
    endfunction

    function automatic logic [4:0] hexval(input logic [7:0] ch);
        // bit 4 = digit valid
        if (is_digit(ch))             return {1'b1, ch[3:0]};
        if (ch >= "a" && ch <= "f")   return {1'b1, 4'(ch - "a" + 8'd10)};
        if (ch >= "A" && ch <= "F")   return {1'b1, 4'(ch - "A" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] ch);
        case (ch)
            "{": return K_LBRACE;   "}": return K_RBRACE;   "[": return K_LBRACK;
            "]": return K_RBRACK;   "(": return K_LPAREN;   ")": return K_RPAREN;
            ";": return K_SEMI;     ",": return K_COMMA;    ".": return K_DOT;
            "?": return K_QUEST;    ":": return K_COLON;    "+": return K_PLUS;
            "-": return K_MINUS;    "*": return K_STAR;     "/": return K_SLASH;
            "%": return K_PERCENT;  "^": return K_CARET;    "~": return K_TILDE;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [5:0] op_single(input logic [7:0] ch);
        case (ch)
            "=": return K_ASSIGN; "!": return K_BANG; "<": return K_LT;
            ">": return K_GT;     "&": return K_AMP;  "|": return K_PIPE;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [5:0] op_pair(input logic [7:0] a, input logic [7:0] b);
        if (b == "=") begin
            if (a == "=") return K_EQ;
            if (a == "!") return K_NE;
            if (a == "<") return K_LE;
            if (a == ">") return K_GE;
        end
        if (a == b) begin
            if (a == "<") return K_SHL;
            if (a == ">") return K_SHR;
            if (a == "&") return K_ANDAND;
            if (a == "|") return K_OROR;
        end
        return K_END;
    endfunction

    // keyword table: true, false, null, include
    function automatic logic [2:0] kw_len(input logic [1:0] k);
        case (k)
            2'd0: return 3'd4;
            2'd1: return 3'd5;
            2'd2: return 3'd4;
            default: return 3'd7;
        endcase
    endfunction

    function automatic logic [5:0] kw_kind(input logic [1:0] k);
        case (k)
            2'd0: return K_TRUE;
            2'd1: return K_FALSE;
            2'd2: return K_NULL;
            default: return K_INCLUDE;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
        logic [55:0] s;
        case (k)
            2'd0: s = {"true", 24'd0};
            2'd1: s = {"false", 16'd0};
            2'd2: s = {"null", 24'd0};
            default: s = "include";
        endcase
        return s[8*(6 - 32'(i)) +: 8];
    endfunction

    function automatic logic [3:0] kw_step(input logic [3:0] kw, input off_t i,
                                           input logic [7:0] ch);
        logic [3:0] r;
        r = kw;
        for (int k = 0; k < 4; k++) begin
            if (i >= off_t'(kw_len(2'(k))) || kw_char(2'(k), i[2:0]) != ch) r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [3:0] kw, input off_t len);
        logic [5:0] kd;
        kd = K_IDENT;
        for (int k = 0; k < 4; k++) begin
            if (kw[k] && len == off_t'(kw_len(2'(k)))) kd = kw_kind(2'(k));
        end
        return kd;
    endfunction

    logic [4:0]  mode_reg, mode_next;
    off_t        pos_reg, pos_next, tstart_reg, tstart_next;
    logic [63:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next, halt_reg, halt_next;
    logic [7:0]  held0_reg, held0_next, held1_reg, held1_next;
    logic [23:0] cp_reg, cp_next;
    logic [2:0]  ecnt_reg, ecnt_next;
    logic [3:0]  kw_reg, kw_next;

    logic        accept, eoi;
    logic [7:0]  c;
    off_t        p, pm1, pm2, pm3, id_len, esc_at, num_end;
    logic [4:0]  hx;
    logic        isd, isa, is_e, is_sgn;
    logic [67:0] acc68, sum68;
    logic        emit_num, num_float, fol_dot, fol_esign, fol_eopen, do_start;
    logic [REC_CNT_W-1:0] n;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign eoi      = in_end;
    // end of input behaves like a NUL byte except where it is checked by name
    assign c        = in_end ? 8'h00 : in_byte;
    assign p        = pos_reg;
    assign pm1      = pos_reg - off_t'(1);
    assign pm2      = pos_reg - off_t'(2);
    assign pm3      = pos_reg - off_t'(3);
    assign id_len   = pos_reg - tstart_reg;
    assign esc_at   = pm3 - off_t'(ecnt_reg);
    assign hx       = hexval(c);
    assign isd      = is_digit(c);
    assign isa      = is_alpha(c);
    assign is_e     = c == "e" || c == "E";
    assign is_sgn   = c == "+" || c == "-";
    assign acc68    = {4'd0, acc_reg};
    assign sum68    = (acc68 << 3) + (acc68 << 1) + {64'd0, c[3:0]};

    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        halt_next   = halt_reg;
        held0_next  = held0_reg;
        held1_next  = held1_reg;
        cp_next     = cp_reg;
        ecnt_next   = ecnt_reg;
        kw_next     = kw_reg;
        bundle      = '0;
        n           = '0;
        emit_num    = 1'b0;
        num_float   = 1'b0;
        num_end     = p;
        fol_dot     = 1'b0;
        fol_esign   = 1'b0;
        fol_eopen   = 1'b0;
        do_start    = 1'b0;

        if (accept && !halt_reg) begin
            case (mode_reg)
                M_IDLE: begin
                    do_start = 1'b1;
                end
                M_LINE: begin
                    if (!eoi && c == 8'h0A) mode_next = M_IDLE;
                end
                M_BLOCK: begin
                    if (eoi) begin
                        bundle.recs[n] = mk_err(E_BLOCK_OPEN, tstart_reg); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end else if (c == "*") begin
                        mode_next = M_BSTAR;
                    end
                end
                M_BSTAR: begin
                    if (eoi) begin
                        bundle.recs[n] = mk_err(E_BLOCK_OPEN, tstart_reg); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end else if (c == "/") begin
                        mode_next = M_IDLE;
                    end else if (c != "*") begin
                        mode_next = M_BLOCK;
                    end
                end
                M_SLASH: begin
                    if (c == "/") begin
                        mode_next = M_LINE;
                    end else if (c == "*") begin
                        mode_next = M_BLOCK;
                    end else begin
                        bundle.recs[n] = mk_tok(K_SLASH, pm1, off_t'(1)); n = n + 1'b1;
                        mode_next = M_IDLE; do_start = 1'b1;
                    end
                end
                M_OP: begin
                    if (op_pair(held0_reg, c) != K_END) begin
                        bundle.recs[n] = mk_tok(op_pair(held0_reg, c), tstart_reg, off_t'(2));
                        n = n + 1'b1;
                        mode_next = M_IDLE;
                    end else begin
                        bundle.recs[n] = mk_tok(op_single(held0_reg), tstart_reg, off_t'(1));
                        n = n + 1'b1;
                        mode_next = M_IDLE; do_start = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (isa || isd) begin
                        kw_next = kw_step(kw_reg, id_len, c);
                    end else begin
                        bundle.recs[n] = mk_tok(ident_kind(kw_reg, id_len), tstart_reg, id_len);
                        n = n + 1'b1;
                        mode_next = M_IDLE; do_start = 1'b1;
                    end
                end
                M_ZERO, M_INT: begin
                    if (mode_reg == M_ZERO && (c == "x" || c == "X")) begin
                        mode_next = M_HEX0;
                    end else if (isd) begin
                        if (!ovf_reg) begin
                            if (sum68 > INT_MAX68) ovf_next = 1'b1;
                            else acc_next = sum68[63:0];
                        end
                        mode_next = M_INT;
                    end else if (c == ".") begin
                        mode_next = M_IDOT;
                    end else if (is_e) begin
                        held0_next = c; mode_next = M_EXPE_I;
                    end else begin
                        emit_num = 1'b1; mode_next = M_IDLE; do_start = 1'b1;
                    end
                end
                M_HEX0: begin
                    if (hx[4]) begin
                        acc_next = {60'd0, hx[3:0]}; mode_next = M_HEX;
                    end else begin
                        bundle.recs[n] = mk_err(E_HEX_EMPTY, tstart_reg); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end
                end
                M_HEX: begin
                    if (hx[4]) begin
                        acc_next = {acc_reg[59:0], hx[3:0]};
                    end else begin
                        emit_num = 1'b1; mode_next = M_IDLE; do_start = 1'b1;
                    end
                end
                M_IDOT: begin
                    if (isd) begin
                        mode_next = M_FRAC;
                    end else begin
                        emit_num = 1'b1; num_end = pm1; fol_dot = 1'b1;
                        mode_next = M_IDLE; do_start = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_e) begin
                        held0_next = c; mode_next = M_EXPE_F;
                    end else if (!isd) begin
                        emit_num = 1'b1; num_float = 1'b1; mode_next = M_IDLE; do_start = 1'b1;
                    end
                end
                M_EXPE_I, M_EXPE_F: begin
                    if (isd) begin
                        mode_next = M_EXPD;
                    end else if (is_sgn) begin
                        held1_next = c;
                        mode_next  = (mode_reg == M_EXPE_F) ? M_SGN_F : M_SGN_I;
                    end else begin
                        emit_num = 1'b1; num_float = (mode_reg == M_EXPE_F); num_end = pm1;
                        fol_eopen = 1'b1; mode_next = M_IDLE;
                    end
                end
                M_SGN_I, M_SGN_F: begin
                    if (isd) begin
                        mode_next = M_EXPD;
                    end else begin
                        emit_num = 1'b1; num_float = (mode_reg == M_SGN_F); num_end = pm2;
                        fol_esign = 1'b1; mode_next = M_IDLE; do_start = 1'b1;
                    end
                end
                M_EXPD: begin
                    if (!isd) begin
                        emit_num = 1'b1; num_float = 1'b1; mode_next = M_IDLE; do_start = 1'b1;
                    end
                end
                M_STR: begin
                    if (eoi) begin
                        bundle.recs[n] = mk_err(E_STR_OPEN, tstart_reg); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end else if (c == "\"") begin
                        bundle.recs[n] = mk_tok(K_STRING, tstart_reg, id_len + off_t'(1));
                        n = n + 1'b1;
                        mode_next = M_IDLE;
                    end else if (c == 8'h0A) begin
                        bundle.recs[n] = mk_err(E_STR_NL, p); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end else if (c == "\\") begin
                        mode_next = M_ESC;
                    end else begin
                        bundle.recs[n] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg), 32'd0,
                                                c, 4'd0);
                        n = n + 1'b1;
                    end
                end
                M_ESC: begin
                    mode_next = M_STR;
                    if (eoi) begin
                        bundle.recs[n] = mk_err(E_ESC_EOF, pm1); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end else if (c == "n" || c == "t" || c == "r" || c == "0" ||
                                 c == "\\" || c == "\"") begin
                        bundle.recs[n] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg), 32'd0,
                                                (c == "n") ? 8'h0A :
                                                (c == "t") ? 8'h09 :
                                                (c == "r") ? 8'h0D :
                                                (c == "0") ? 8'h00 : c, 4'd0);
                        n = n + 1'b1;
                    end else if (c == "x") begin
                        mode_next = M_X1;
                    end else if (c == "u") begin
                        mode_next = M_UBR;
                    end else begin
                        bundle.recs[n] = mk_err(E_BAD_ESC, pm1); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end
                end
                M_X1: begin
                    if (hx[4]) begin
                        cp_next = {20'd0, hx[3:0]}; mode_next = M_X2;
                    end else begin
                        bundle.recs[n] = mk_err(E_BAD_X, pm2); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end
                end
                M_X2: begin
                    if (hx[4]) begin
                        bundle.recs[n] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg), 32'd0,
                                                {cp_reg[3:0], hx[3:0]}, 4'd0);
                        n = n + 1'b1;
                        mode_next = M_STR;
                    end else begin
                        bundle.recs[n] = mk_err(E_BAD_X, pm3); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end
                end
                M_UBR: begin
                    if (c == "{") begin
                        cp_next = '0; ecnt_next = '0; mode_next = M_UDIG;
                    end else begin
                        bundle.recs[n] = mk_err(E_U_NO_BRACE, pm2); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end
                end
                M_UDIG: begin
                    if (hx[4]) begin
                        if (ecnt_reg >= 3'd6) begin
                            bundle.recs[n] = mk_err(E_U_LONG, esc_at); n = n + 1'b1;
                            halt_next = 1'b1; mode_next = M_IDLE;
                        end else begin
                            cp_next   = {cp_reg[19:0], hx[3:0]};
                            ecnt_next = ecnt_reg + 3'd1;
                        end
                    end else if (ecnt_reg == 3'd0) begin
                        bundle.recs[n] = mk_err(E_U_EMPTY, esc_at); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end else if (c != "}") begin
                        bundle.recs[n] = mk_err(E_U_OPEN, esc_at); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end else if (cp_reg > 24'h10FFFF ||
                                 (cp_reg >= 24'hD800 && cp_reg <= 24'hDFFF)) begin
                        bundle.recs[n] = mk_err(E_BAD_CP, esc_at); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end else begin
                        // UTF-8 encode, one to four payload beats
                        mode_next = M_STR;
                        if (cp_reg <= 24'h7F) begin
                            bundle.recs[0] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, cp_reg[7:0], 4'd0);
                            n = REC_CNT_W'(1);
                        end else if (cp_reg <= 24'h7FF) begin
                            bundle.recs[0] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, {3'b110, cp_reg[10:6]}, 4'd0);
                            bundle.recs[1] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, {2'b10, cp_reg[5:0]}, 4'd0);
                            n = REC_CNT_W'(2);
                        end else if (cp_reg <= 24'hFFFF) begin
                            bundle.recs[0] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, {4'b1110, cp_reg[15:12]}, 4'd0);
                            bundle.recs[1] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, {2'b10, cp_reg[11:6]}, 4'd0);
                            bundle.recs[2] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, {2'b10, cp_reg[5:0]}, 4'd0);
                            n = REC_CNT_W'(3);
                        end else begin
                            bundle.recs[0] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, {5'b11110, cp_reg[20:18]}, 4'd0);
                            bundle.recs[1] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, {2'b10, cp_reg[17:12]}, 4'd0);
                            bundle.recs[2] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, {2'b10, cp_reg[11:6]}, 4'd0);
                            bundle.recs[3] = mk_rec(RT_PAYLOAD, K_STRING, to32(tstart_reg),
                                                    32'd0, {2'b10, cp_reg[5:0]}, 4'd0);
                            n = REC_CNT_W'(4);
                        end
                    end
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase

            // pending number, then any held bytes that get lexed again
            if (emit_num) begin
                if (!num_float && ovf_reg) begin
                    bundle.recs[n] = mk_err(E_DEC_RANGE, tstart_reg); n = n + 1'b1;
                    halt_next = 1'b1; mode_next = M_IDLE;
                    fol_dot = 1'b0; fol_esign = 1'b0; fol_eopen = 1'b0; do_start = 1'b0;
                end else begin
                    bundle.recs[n] = mk_tok(num_float ? K_FLOAT : K_INT, tstart_reg,
                                            num_end - tstart_reg);
                    n = n + 1'b1;
                    if (!num_float) bundle.ival = acc_reg;
                end
            end
            if (fol_dot) begin
                bundle.recs[n] = mk_tok(K_DOT, pm1, off_t'(1)); n = n + 1'b1;
            end
            if (fol_esign) begin
                bundle.recs[n] = mk_tok(K_IDENT, pm2, off_t'(1)); n = n + 1'b1;
                bundle.recs[n] = mk_tok((held1_reg == "+") ? K_PLUS : K_MINUS, pm1, off_t'(1));
                n = n + 1'b1;
            end
            if (fol_eopen) begin
                // held 'e' starts an identifier that matches no keyword
                if (isa || isd) begin
                    mode_next = M_IDENT; tstart_next = pm1; kw_next = '0;
                end else begin
                    bundle.recs[n] = mk_tok(K_IDENT, pm1, off_t'(1)); n = n + 1'b1;
                    do_start = 1'b1;
                end
            end

            if (do_start && !eoi && !is_space(c)) begin
                if (c == "#") begin
                    mode_next = M_LINE;
                end else begin
                    tstart_next = p;
                    if (c == "/") begin
                        mode_next = M_SLASH;
                    end else if (isa) begin
                        mode_next = M_IDENT;
                        kw_next   = kw_step(4'hF, '0, c);
                    end else if (isd) begin
                        acc_next  = {60'd0, c[3:0]};
                        ovf_next  = 1'b0;
                        mode_next = (c == "0") ? M_ZERO : M_INT;
                    end else if (c == "\"") begin
                        mode_next = M_STR;
                    end else if (op_single(c) != K_END) begin
                        held0_next = c; mode_next = M_OP;
                    end else if (single_kind(c) != K_END) begin
                        bundle.recs[n] = mk_tok(single_kind(c), p, off_t'(1)); n = n + 1'b1;
                    end else begin
                        bundle.recs[n] = mk_err(E_BAD_CHAR, p); n = n + 1'b1;
                        halt_next = 1'b1; mode_next = M_IDLE;
                    end
                end
            end
        end

        if (accept) begin
            if (eoi) begin
                if (!halt_reg && !halt_next) begin
                    bundle.recs[n] = mk_tok(K_END, p, '0); n = n + 1'b1;
                end
                mode_next   = M_IDLE;
                pos_next    = '0;
                tstart_next = '0;
                acc_next    = '0;
                ovf_next    = 1'b0;
                halt_next   = 1'b0;
                held0_next  = '0;
                held1_next  = '0;
                cp_next     = '0;
                ecnt_next   = '0;
                kw_next     = 4'hF;
            end else begin
                pos_next = pos_reg + off_t'(1);
            end
        end
        bundle.cnt = n;
    end

    assign push = accept && (n != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            halt_reg   <= 1'b0;
            held0_reg  <= '0;
            held1_reg  <= '0;
            cp_reg     <= '0;
            ecnt_reg   <= '0;
            kw_reg     <= 4'hF;
        end else begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
            halt_reg   <= halt_next;
            held0_reg  <= held0_next;
            held1_reg  <= held1_next;
            cp_reg     <= cp_next;
            ecnt_reg   <= ecnt_next;
            kw_reg     <= kw_next;
        end
    end

endmodule

/* rtl/core/cst_queue.sv */
`include "config_script_tokenizer_top_assert.svh"

module cst_queue import cst_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t wdata,
    input  logic    pop,
    output bundle_t rdata,
    output logic    full,
    output logic    empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    bundle_t            mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == CNT_W'(QDEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    `CST_ASSERT_IMP(a_no_overflow, push, !full || pop)
    `CST_ASSERT_IMP(a_no_underflow, pop, !empty)
    `CST_ASSERT_IMP(a_bundle_nonempty, push, wdata.cnt != '0)

endmodule

/* rtl/core/cst_back.sv */
module cst_back import cst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  bundle_t     head,
    input  logic        head_valid,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output rec_t        out_rec,
    output logic [63:0] out_ival,
    output logic        out_last
);

    localparam int IDX_W = $clog2(REC_MAX);
    localparam int CW1   = REC_CNT_W + 1;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    rec_t             rec_reg;
    logic [63:0]      ival_reg;
    logic             last_reg;
    logic             load, is_last;
    rec_t             cur;

    assign cur     = head.recs[idx_reg];
    assign is_last = (CW1'(idx_reg) + CW1'(1)) == CW1'(head.cnt);
    assign load    = head_valid && (!valid_reg || out_ready);
    assign pop     = load && is_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg  <= cur;
            ival_reg <= (cur.rtype == RT_TOKEN && cur.kind == K_INT) ? head.ival : 64'd0;
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;
    assign out_ival  = ival_reg;
    assign out_last  = last_reg;

endmodule
